// ===== hdl/fbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and functions
// Block half types, configuration codes and the Feistel round function.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int HALF_W   = 32;
  localparam int KEY_W    = 64;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 8'd1;

  typedef logic [HALF_W-1:0] half_t;

  // Running halves of one block inside the round pipeline
  typedef struct packed {
    half_t a;
    half_t b;
  } blk_t;

  // One round: a' = b ^ rotl(a,9) ^ ~(rotr(k,11) ^ a), b' = a
  function automatic blk_t round_f(input blk_t cur, input half_t rkey);
    blk_t  res;
    half_t rot_a;
    half_t rot_k;
    rot_a = {cur.a[22:0], cur.a[31:23]};
    rot_k = {rkey[10:0], rkey[31:11]};
    res.a = cur.b ^ rot_a ^ ~(rot_k ^ cur.a);
    res.b = cur.a;
    return res;
  endfunction

endpackage

// ===== hdl/fbc_in_if.sv =====
// ----------------------------------------------------------------------------
// fbc_in_if: input block channel
// Valid/ready channel carrying the two halves of one plaintext block.
// ----------------------------------------------------------------------------
interface fbc_in_if;
  logic           valid;
  logic           ready;
  fbc_pkg::half_t left_half;
  fbc_pkg::half_t right_half;

  modport source (output valid, output left_half, output right_half, input ready);
  modport sink   (input valid, input left_half, input right_half, output ready);
endinterface

// ===== hdl/fbc_out_if.sv =====
// ----------------------------------------------------------------------------
// fbc_out_if: result block channel
// Valid/ready channel carrying the two halves of one result block.
// ----------------------------------------------------------------------------
interface fbc_out_if;
  logic           valid;
  logic           ready;
  fbc_pkg::half_t out_left;
  fbc_pkg::half_t out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// ===== hdl/fbc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// fbc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface fbc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fbc_pkg::CFG_IDX_W-1:0]     index;
  logic [fbc_pkg::CFG_DAT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/fbc_key_sched.sv =====
// ----------------------------------------------------------------------------
// fbc_key_sched: configuration registers and round key schedule
// Holds the key and mode registers and derives one round key per stage.
// ----------------------------------------------------------------------------
module fbc_key_sched #(
  parameter int NUM_ROUNDS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  fbc_cfg_if.sink              cfg,
  output fbc_pkg::half_t       rkey [NUM_ROUNDS]
);

  logic [fbc_pkg::KEY_W-1:0] key_r;
  logic                      decrypt_r;
  fbc_pkg::half_t            sched [NUM_ROUNDS];

  // Always take writes; unknown indexes drop
  assign cfg.ready = 1'b1;

  // Update key and mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      decrypt_r <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        fbc_pkg::REG_CIPHER_KEY:   key_r     <= cfg.data;
        fbc_pkg::REG_DECRYPT_MODE: decrypt_r <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Step j has rotated the key right by the sum of 3*i for i <= j, mod 64
  for (genvar j = 0; j < NUM_ROUNDS; j++) begin : g_sched
    localparam int SH = ((3 * j * (j + 1)) / 2) % fbc_pkg::KEY_W;
    logic [2*fbc_pkg::KEY_W-1:0] dbl;
    assign dbl      = {key_r, key_r} >> SH;
    assign sched[j] = dbl[fbc_pkg::HALF_W-1:0];
  end

  // Reverse the key order in decrypt mode
  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_order
    assign rkey[r] = decrypt_r ? sched[NUM_ROUNDS-1-r] : sched[r];
  end

endmodule

// ===== hdl/fbc_round.sv =====
// ----------------------------------------------------------------------------
// fbc_round: one registered Feistel round stage
// Applies one round to the incoming block and holds it under backpressure.
// ----------------------------------------------------------------------------
module fbc_round (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  fbc_pkg::blk_t  in_data,
  input  fbc_pkg::half_t rkey,
  output logic           out_valid,
  input  logic           out_ready,
  output fbc_pkg::blk_t  out_data
);

  logic          vld_r;
  fbc_pkg::blk_t data_r;

  // Advance when the stage is empty or its contents move on
  assign in_ready = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  // Capture the round result on each transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= fbc_pkg::round_f(in_data, rkey);
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

// ===== hdl/feistel_block_cipher_64.sv =====
// ----------------------------------------------------------------------------
// feistel_block_cipher_64: pipelined 64-bit Feistel cipher
// Encrypts or decrypts one block per cycle, unless out_ch stalls, through unrolled round stages.
// ----------------------------------------------------------------------------
//  channel  | dir | fields                  | transaction
//  ---------+-----+-------------------------+-----------------------------
//  in_ch    | in  | left_half, right_half   | valid & ready
//  out_ch   | out | out_left, out_right     | valid & ready
//  cfg_ch   | in  | index, data             | valid & ready (ready tied high)
//
// Throughput is one block per cycle while out_ch takes results; the path holds
// an input register, one register per round, and an output register.
// Round keys are wired from the key and mode registers, one per stage.
// Reset clears all stage valid bits and sets key 0, encrypt mode.
// A stall at out_ch holds each full stage whose later stages are all full; ready
// ripples back through the stage chain so no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module feistel_block_cipher_64 #(
  parameter int NUM_ROUNDS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  fbc_in_if.sink   in_ch,
  fbc_out_if.source out_ch,
  fbc_cfg_if.sink  cfg_ch
);

  fbc_pkg::half_t rkey [NUM_ROUNDS];

  logic           lnk_valid [NUM_ROUNDS+1];
  logic           lnk_ready [NUM_ROUNDS+1];
  fbc_pkg::blk_t  lnk_data  [NUM_ROUNDS+1];

  logic           in_vld_r;
  fbc_pkg::blk_t  in_data_r;
  logic           out_vld_r;
  fbc_pkg::blk_t  out_data_r;

  // Key registers and schedule
  fbc_key_sched #(
    .NUM_ROUNDS (NUM_ROUNDS)
  ) u_key_sched (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .rkey  (rkey)
  );

  // Input register stage
  assign in_ch.ready = !in_vld_r || lnk_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data_r.a <= in_ch.left_half;
      in_data_r.b <= in_ch.right_half;
    end
  end

  assign lnk_valid[0] = in_vld_r;
  assign lnk_data[0]  = in_data_r;

  // Round stages
  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
    fbc_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (lnk_valid[r]),
      .in_ready  (lnk_ready[r]),
      .in_data   (lnk_data[r]),
      .rkey      (rkey[r]),
      .out_valid (lnk_valid[r+1]),
      .out_ready (lnk_ready[r+1]),
      .out_data  (lnk_data[r+1])
    );
  end

  // Output register stage; swap halves on the way out
  assign lnk_ready[NUM_ROUNDS] = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (lnk_ready[NUM_ROUNDS]) begin
      out_vld_r <= lnk_valid[NUM_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (lnk_valid[NUM_ROUNDS] && lnk_ready[NUM_ROUNDS]) begin
      out_data_r <= lnk_data[NUM_ROUNDS];
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.out_left  = out_data_r.b;
  assign out_ch.out_right = out_data_r.a;

endmodule

// ===== tb/tb_feistel_block_cipher_64.sv =====
// ----------------------------------------------------------------------------
// tb_feistel_block_cipher_64: self-checking bench for the Feistel cipher
// Streams blocks through the cipher under several key/mode settings, predicts
// each result from a local round-key schedule and compares it field by field,
// with random source gaps, random sink stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_feistel_block_cipher_64;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ROUNDS  = 16;
  localparam int LATENCY     = NUM_ROUNDS + 2;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 100000;

  // Indexes that map to no register; writes there must be ignored
  localparam logic [fbc_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
  localparam logic [fbc_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

  typedef struct packed {
    fbc_pkg::half_t left;
    fbc_pkg::half_t right;
  } block_pair_t;

  logic clk = 1'b0;
  logic rst_n;

  fbc_in_if  blk_in ();
  fbc_out_if blk_out ();
  fbc_cfg_if reg_wr ();

  feistel_block_cipher_64 #(
    .NUM_ROUNDS(NUM_ROUNDS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (blk_in),
    .out_ch(blk_out),
    .cfg_ch(reg_wr)
  );

  // Generate a 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the key registers and the derived schedule
  logic [fbc_pkg::KEY_W-1:0] model_key;
  logic                      model_decrypt;
  fbc_pkg::half_t            round_keys [NUM_ROUNDS];

  block_pair_t pending_blocks [$];
  block_pair_t expected_blocks [$];

  int unsigned n_queued     = 0;
  int unsigned n_accepted   = 0;
  int unsigned n_checked    = 0;
  int unsigned n_settings   = 0;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;

  bit src_no_gap   = 1'b0;
  bit snk_no_stall = 1'b0;
  int unsigned hold_token = 0;
  int unsigned hold_seen  = 0;
  int          gap_left   = 0;
  int          stall_left = 0;
  int          hold_left  = 0;
  logic        in_vld_next;
  logic        out_rdy_next;
  block_pair_t next_blk;
  block_pair_t want_blk;

  function automatic logic [63:0] ror64(input logic [63:0] v, input int unsigned n);
    int unsigned s;
    s = n % 64;
    if (s == 0) return v;
    return (v >> s) | (v << (64 - s));
  endfunction

  function automatic fbc_pkg::half_t rol32(input fbc_pkg::half_t v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic fbc_pkg::half_t ror32(input fbc_pkg::half_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // Rebuild the round keys from the key and mode copies
  function automatic void derive_round_keys();
    logic [63:0] run;
    run = model_key;
    for (int j = 0; j < NUM_ROUNDS; j++) begin
      run = ror64(run, 3 * j);
      if (model_decrypt) round_keys[NUM_ROUNDS-1-j] = run[31:0];
      else               round_keys[j] = run[31:0];
    end
  endfunction

  // Run all rounds on one block; output left is final b, right is final a
  function automatic block_pair_t cipher_block(input fbc_pkg::half_t left,
                                               input fbc_pkg::half_t right);
    fbc_pkg::half_t a;
    fbc_pkg::half_t b;
    fbc_pkg::half_t na;
    block_pair_t    res;
    a = left;
    b = right;
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      na = b ^ rol32(a, 9) ^ ~(ror32(round_keys[r], 11) ^ a);
      b  = a;
      a  = na;
    end
    res.left  = b;
    res.right = a;
    return res;
  endfunction

  // Source side: present queued blocks, predict each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      blk_in.valid <= 1'b0;
      gap_left = 0;
    end else begin
      in_vld_next = blk_in.valid;
      if (blk_in.valid && blk_in.ready) begin
        expected_blocks.push_back(cipher_block(blk_in.left_half, blk_in.right_half));
        n_accepted++;
        in_vld_next = 1'b0;
        gap_left = src_no_gap ? 0 : $urandom_range(4);
      end
      if (!in_vld_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_blocks.size() > 0) begin
          next_blk = pending_blocks.pop_front();
          blk_in.left_half  <= next_blk.left;
          blk_in.right_half <= next_blk.right;
          in_vld_next = 1'b1;
        end
      end
      blk_in.valid <= in_vld_next;
    end
  end

  // Sink side: check each result transaction, stall and hold off at random
  always @(posedge clk) begin
    if (!rst_n) begin
      blk_out.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (blk_out.valid && blk_out.ready) begin
        if (expected_blocks.size() == 0) begin
          $error("unexpected result: out_left=%h out_right=%h",
                 blk_out.out_left, blk_out.out_right);
          error_count++;
        end else begin
          want_blk = expected_blocks.pop_front();
          if (blk_out.out_left !== want_blk.left) begin
            $error("out_left: expected %h, got %h", want_blk.left, blk_out.out_left);
            error_count++;
          end
          if (blk_out.out_right !== want_blk.right) begin
            $error("out_right: expected %h, got %h", want_blk.right, blk_out.out_right);
            error_count++;
          end
          n_checked++;
        end
        stall_left = snk_no_stall ? 0 : $urandom_range(4);
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_rdy_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_rdy_next = 1'b0;
      end else begin
        out_rdy_next = 1'b1;
      end
      blk_out.ready <= out_rdy_next;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_block(input fbc_pkg::half_t left, input fbc_pkg::half_t right);
    block_pair_t b;
    b.left  = left;
    b.right = right;
    pending_blocks.push_back(b);
    n_queued++;
  endtask

  // Wait until every queued block is accepted and its result checked
  task automatic wait_drained();
    while (n_accepted != n_queued || n_checked != n_accepted) @(posedge clk);
  endtask

  // One register write transaction; mirror it in the local model
  task automatic write_reg(input logic [fbc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fbc_pkg::CFG_DAT_W-1:0] data);
    @(posedge clk);
    reg_wr.valid <= 1'b1;
    reg_wr.index <= idx;
    reg_wr.data  <= data;
    do @(posedge clk); while (!reg_wr.ready);
    reg_wr.valid <= 1'b0;
    n_settings++;
    case (idx)
      fbc_pkg::REG_CIPHER_KEY:   model_key = data;
      fbc_pkg::REG_DECRYPT_MODE: model_decrypt = data[0];
      default:                   return;
    endcase
    derive_round_keys();
  endtask

  // Mostly random halves, with the extremes now and then
  function automatic fbc_pkg::half_t pick_half();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_n             = 1'b0;
    blk_in.valid      = 1'b0;
    blk_in.left_half  = '0;
    blk_in.right_half = '0;
    blk_out.ready     = 1'b0;
    reg_wr.valid      = 1'b0;
    reg_wr.index      = '0;
    reg_wr.data       = '0;
    model_key         = '0;
    model_decrypt     = 1'b0;
    derive_round_keys();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset schedule: key 0, encrypt
    push_block(32'h0000_0000, 32'h0000_0000);
    push_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_block(32'h0000_0000, 32'hFFFF_FFFF);
    push_block(32'hFFFF_FFFF, 32'h0000_0000);
    push_block(32'h8000_0000, 32'h0000_0001);
    push_block(32'h0000_0001, 32'h8000_0000);
    push_block(32'hAAAA_AAAA, 32'h5555_5555);
    push_block(32'h1234_5678, 32'h9ABC_DEF0);
    wait_drained();

    // All-ones key, encrypt
    write_reg(fbc_pkg::REG_CIPHER_KEY, 64'hFFFF_FFFF_FFFF_FFFF);
    push_block(32'h0000_0000, 32'h0000_0000);
    push_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_block(32'h5555_5555, 32'hAAAA_AAAA);
    push_block(32'hDEAD_BEEF, 32'h0BAD_F00D);
    wait_drained();

    // Decrypt with every mode bit set; only bit 0 counts
    write_reg(fbc_pkg::REG_DECRYPT_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
    push_block(32'h0000_0000, 32'h0000_0000);
    push_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_block(32'h0000_0000, 32'hFFFF_FFFF);
    push_block(32'hFFFF_FFFF, 32'h0000_0000);
    wait_drained();

    // Writes to unused indexes change nothing
    write_reg(REG_UNUSED_LO, {$urandom, $urandom});
    write_reg(REG_UNUSED_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    push_block(32'h0000_0000, 32'h0000_0000);
    push_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_block(32'h8000_0000, 32'h0000_0001);
    wait_drained();

    // Mode 0 with high data bits set, sparse key
    write_reg(fbc_pkg::REG_CIPHER_KEY, 64'h8000_0000_0000_0001);
    write_reg(fbc_pkg::REG_DECRYPT_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    push_block(32'h0000_0000, 32'h0000_0000);
    push_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_block(32'h0123_4567, 32'h89AB_CDEF);
    wait_drained();

    // Random phases: new key and mode each, varied idling in chunks
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       write_reg(fbc_pkg::REG_CIPHER_KEY, 64'h0);
        5:       write_reg(fbc_pkg::REG_CIPHER_KEY, 64'hFFFF_FFFF_FFFF_FFFF);
        default: write_reg(fbc_pkg::REG_CIPHER_KEY, {$urandom, $urandom});
      endcase
      if (ph == 0) write_reg(fbc_pkg::REG_DECRYPT_MODE, 64'h1);
      else         write_reg(fbc_pkg::REG_DECRYPT_MODE, {$urandom, $urandom});
      for (int ck = 0; ck < 4; ck++) begin
        src_no_gap   = ($urandom_range(3) == 0);
        snk_no_stall = ($urandom_range(3) == 0);
        // Hold the output off while the source streams, to fill the pipe
        if (ph == 2 && ck == 1) begin
          src_no_gap = 1'b1;
          hold_token++;
        end
        for (int i = 0; i < 25; i++) push_block(pick_half(), pick_half());
        while (n_accepted != n_queued) @(posedge clk);
      end
      wait_drained();
    end

    // Let the pipeline settle and catch any stray result
    repeat (LATENCY + 10) @(posedge clk);
    if (expected_blocks.size() != 0) begin
      $error("%0d expected results never arrived", expected_blocks.size());
      error_count++;
    end

    $display("Checked %0d blocks across %0d register writes, encrypt and decrypt,",
             n_checked, n_settings);
    $display("with random source gaps, sink stalls and one long output hold-off.");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
